FILE: hdl/ctgt_pkg.sv
// ----------------------------------------------------------------------------
// ctgt_pkg
// Shared types and constants of the counter to game tick converter.
// ----------------------------------------------------------------------------
package ctgt_pkg;

    // word widths
    localparam int SAMPLE_W = 64;
    localparam int FREQ_W   = 32;
    localparam int TIME_W   = 32;
    localparam int ELAP_W   = 40;
    localparam int SCALE_W  = 45;
    localparam int SHIFT_W  = 17;
    localparam int DVD_W    = SCALE_W + SHIFT_W;
    localparam int CNT_W    = $clog2(DVD_W);

    // game time per counter second is 25 * 2^17
    localparam logic [SCALE_W-1:0] SCALE_MULT = SCALE_W'(25);
    localparam logic [TIME_W-1:0]  START_TICK = TIME_W'(65536);
    localparam logic [FREQ_W-1:0]  FREQ_RESET = FREQ_W'(10000000);

    // command codes
    localparam logic CMD_INIT = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ELAP,
        ST_SCALE,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic take;
        logic elap;
        logic scale;
        logic div_step;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic slow;
        logic div_last;
        logic out_free;
    } t_status;

endpackage

FILE: hdl/ctgt_if.sv
// ----------------------------------------------------------------------------
// ctgt interfaces
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
interface ctgt_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [63:0] counter_sample;
    logic        window_active;

    modport source (output valid, output command, output counter_sample,
                    output window_active, input ready);
    modport sink   (input valid, input command, input counter_sample,
                    input window_active, output ready);
endinterface

interface ctgt_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] tick_length;
    logic signed [31:0] total_time;

    modport source (output valid, output tick_length, output total_time, input ready);
    modport sink   (input valid, input tick_length, input total_time, output ready);
endinterface

FILE: hdl/ctgt_ctrl.sv
// ----------------------------------------------------------------------------
// ctgt_ctrl
// Sequencer: takes a word, steps the datapath through elapsed time and, for
// active ticks, scaling and bit-serial division, then hands the result over.
// ----------------------------------------------------------------------------
module ctgt_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  ctgt_pkg::t_status  i_status,
    output logic               o_in_ready,
    output ctgt_pkg::t_cmd     o_cmd
);

    ctgt_pkg::t_state r_state;
    ctgt_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ctgt_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ctgt_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = ctgt_pkg::ST_ELAP;
                end
            end
            ctgt_pkg::ST_ELAP: begin
                o_cmd.elap = 1'b1;
                n_state    = i_status.slow ? ctgt_pkg::ST_SCALE : ctgt_pkg::ST_DONE;
            end
            ctgt_pkg::ST_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = ctgt_pkg::ST_DIV;
            end
            ctgt_pkg::ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = ctgt_pkg::ST_DONE;
                end
            end
            ctgt_pkg::ST_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ctgt_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ctgt_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: hdl/ctgt_dpath.sv
// ----------------------------------------------------------------------------
// ctgt_dpath
// Timer state, elapsed count, scaling, restoring divider and result register.
// ----------------------------------------------------------------------------
module ctgt_dpath (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_wr_en,
    input  logic [ctgt_pkg::FREQ_W-1:0]           i_cfg_wr_data,
    input  ctgt_pkg::t_cmd                        i_cmd,
    output ctgt_pkg::t_status                     o_status,
    input  logic                                  i_command,
    input  logic [ctgt_pkg::SAMPLE_W-1:0]         i_counter_sample,
    input  logic                                  i_window_active,
    input  logic                                  i_out_ready,
    output logic                                  o_out_valid,
    output logic signed [ctgt_pkg::TIME_W-1:0]    o_tick_length,
    output logic signed [ctgt_pkg::TIME_W-1:0]    o_total_time
);

    // configuration and timer state
    logic [ctgt_pkg::FREQ_W-1:0]   r_freq;
    logic                          r_pending;
    logic [ctgt_pkg::SAMPLE_W-1:0] r_prev;
    logic [ctgt_pkg::FREQ_W-1:0]   r_carry;
    logic [ctgt_pkg::TIME_W-1:0]   r_acc;

    // latched word
    logic                          r_command;
    logic [ctgt_pkg::SAMPLE_W-1:0] r_sample;
    logic                          r_active;

    // arithmetic
    logic [ctgt_pkg::ELAP_W-1:0]   r_elapsed;
    logic [ctgt_pkg::DVD_W-1:0]    r_dvd;
    logic [ctgt_pkg::FREQ_W-1:0]   r_divisor;
    logic [ctgt_pkg::FREQ_W-1:0]   r_rem;
    logic [ctgt_pkg::TIME_W-1:0]   r_quot;
    logic [ctgt_pkg::CNT_W-1:0]    r_cnt;

    // result register
    logic                          r_out_valid;
    logic [ctgt_pkg::TIME_W-1:0]   r_out_tick;
    logic [ctgt_pkg::TIME_W-1:0]   r_out_total;

    logic [ctgt_pkg::SAMPLE_W-1:0] w_diff;
    logic [ctgt_pkg::ELAP_W-1:0]   w_sat;
    logic [ctgt_pkg::SCALE_W-1:0]  w_scaled;
    logic [ctgt_pkg::FREQ_W:0]     w_rem_sh;
    logic [ctgt_pkg::FREQ_W:0]     w_rem_sub;
    logic                          w_ge;
    logic                          w_slow;
    logic [ctgt_pkg::TIME_W-1:0]   w_tick;

    // elapsed count, wrapping then saturated
    assign w_diff = r_sample - r_prev;
    assign w_sat  = (|w_diff[ctgt_pkg::SAMPLE_W-1:ctgt_pkg::ELAP_W])
                    ? '1 : w_diff[ctgt_pkg::ELAP_W-1:0];

    assign w_scaled = {{(ctgt_pkg::SCALE_W-ctgt_pkg::ELAP_W){1'b0}}, r_elapsed}
                      * ctgt_pkg::SCALE_MULT;

    // one restoring division step
    assign w_rem_sh  = {r_rem, r_dvd[ctgt_pkg::DVD_W-1]};
    assign w_rem_sub = w_rem_sh - {1'b0, r_divisor};
    assign w_ge      = !w_rem_sub[ctgt_pkg::FREQ_W];

    assign w_slow = (r_command == ctgt_pkg::CMD_TICK) && !r_pending && r_active;

    // tick length of the current word
    always_comb begin
        priority if (r_command == ctgt_pkg::CMD_INIT) begin
            w_tick = '0;
        end else if (r_pending) begin
            w_tick = ctgt_pkg::START_TICK;
        end else if (r_active) begin
            w_tick = r_quot;
        end else begin
            w_tick = '0;
        end
    end

    assign o_status.slow     = w_slow;
    assign o_status.div_last = (r_cnt == ctgt_pkg::CNT_W'(ctgt_pkg::DVD_W - 1));
    assign o_status.out_free = !r_out_valid || i_out_ready;

    // frequency register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq <= ctgt_pkg::FREQ_RESET;
        end else if (i_cfg_wr_en) begin
            r_freq <= i_cfg_wr_data;
        end
    end

    // timer state, updated when a result is handed over
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 1'b0;
            r_prev    <= '0;
            r_carry   <= '0;
            r_acc     <= '0;
        end else if (i_cmd.commit) begin
            r_prev <= r_sample;
            if (r_command == ctgt_pkg::CMD_INIT) begin
                r_pending <= 1'b1;
                r_carry   <= '0;
                r_acc     <= '0;
            end else begin
                r_pending <= 1'b0;
                r_acc     <= r_acc + w_tick;
                if (w_slow) begin
                    r_carry <= r_rem;
                end
            end
        end
    end

    // input word capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_command <= i_command;
            r_sample  <= i_counter_sample;
            r_active  <= i_window_active;
        end
    end

    // elapsed, scaling and division
    always_ff @(posedge i_clk) begin
        if (i_cmd.elap) begin
            r_elapsed <= w_sat;
        end
        if (i_cmd.scale) begin
            r_dvd     <= {w_scaled, {ctgt_pkg::SHIFT_W{1'b0}}}
                         + {{(ctgt_pkg::DVD_W-ctgt_pkg::FREQ_W){1'b0}}, r_carry};
            r_divisor <= (r_freq == '0) ? ctgt_pkg::FREQ_W'(1) : r_freq;
            r_rem     <= '0;
            r_quot    <= '0;
        end else if (i_cmd.div_step) begin
            r_dvd  <= {r_dvd[ctgt_pkg::DVD_W-2:0], 1'b0};
            r_rem  <= w_ge ? w_rem_sub[ctgt_pkg::FREQ_W-1:0]
                           : w_rem_sh[ctgt_pkg::FREQ_W-1:0];
            r_quot <= {r_quot[ctgt_pkg::TIME_W-2:0], w_ge};
        end
    end

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.scale) begin
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_cnt <= r_cnt + ctgt_pkg::CNT_W'(1);
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_tick  <= w_tick;
            r_out_total <= (r_command == ctgt_pkg::CMD_INIT) ? '0 : r_acc + w_tick;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_tick_length = $signed(r_out_tick);
    assign o_total_time  = $signed(r_out_total);

endmodule

FILE: hdl/counter_to_game_tick_converter.sv
// ----------------------------------------------------------------------------
// counter_to_game_tick_converter
// Drift-free conversion of free-running counter samples into game time.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one word per handshake: command (init or tick), the counter
//   sample and the window flag. o_out returns exactly one result word per
//   input word: the tick length and the wrapped running total.
//   i_cfg_wr_en / i_cfg_wr_data write the counter frequency (divisor); write
//   it only while no word is in flight.
// Sequence:
//   init, start and inactive ticks: the elapsed count is latched, then the
//   result is loaded once the output register is free. Active ticks: the
//   elapsed count is latched and scaled, then the 62-bit dividend goes
//   through a restoring divider one bit per cycle before the result is loaded.
//   i_in.ready is high only between words, so a new word is taken only once
//   the previous result is loaded.
// Reset:
//   clears the timer state, the pending flag and the result valid flag, and
//   sets the frequency to 10 MHz.
// Stall:
//   a result waits in the output register; one further word can be taken
//   and worked on, then the block holds until the waiting word is taken.
// ----------------------------------------------------------------------------
module counter_to_game_tick_converter (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [ctgt_pkg::FREQ_W-1:0]    i_cfg_wr_data,
    ctgt_in_if.sink                        i_in,
    ctgt_out_if.source                     o_out
);

    ctgt_pkg::t_cmd    w_cmd;
    ctgt_pkg::t_status w_status;

    // sequencer
    ctgt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_status   (w_status),
        .o_in_ready (i_in.ready),
        .o_cmd      (w_cmd)
    );

    // datapath
    ctgt_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .i_command        (i_in.command),
        .i_counter_sample (i_in.counter_sample),
        .i_window_active  (i_in.window_active),
        .i_out_ready      (o_out.ready),
        .o_out_valid      (o_out.valid),
        .o_tick_length    (o_out.tick_length),
        .o_total_time     (o_out.total_time)
    );

endmodule

FILE: hdl/ctgt_chk.sv
// ----------------------------------------------------------------------------
// ctgt_chk
// Port-level checks of the counter to game tick converter.
// ----------------------------------------------------------------------------
module ctgt_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_tick_length,
    input logic [31:0] i_total_time
);

    // a taken word closes the input; only the drop of ready is checked
    a_ready_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input still open after a word was taken");

    // no result straight after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // a waiting result stays
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result dropped while stalled");

    // a waiting result keeps its value
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> ($stable(i_tick_length) && $stable(i_total_time)))
        else $error("result changed while stalled");

endmodule

bind counter_to_game_tick_converter ctgt_chk u_ctgt_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_tick_length (o_out.tick_length),
    .i_total_time  (o_out.total_time)
);
